// ----- hw/rtl/hsvb_pkg.sv -----
package hsvb_pkg;

   // Color source codes carried in the op field.
   localparam logic OP_HSV = 1'b0;
   localparam logic OP_RGB = 1'b1;

   // Hue sector codes, one per 60 degree span.
   localparam logic [2:0] SECTOR_0 = 3'd0;
   localparam logic [2:0] SECTOR_1 = 3'd1;
   localparam logic [2:0] SECTOR_2 = 3'd2;
   localparam logic [2:0] SECTOR_3 = 3'd3;
   localparam logic [2:0] SECTOR_4 = 3'd4;
   localparam logic [2:0] SECTOR_5 = 3'd5;

   localparam logic [9:0]  HUE_RANGE   = 10'd360;
   localparam logic [8:0]  SECTOR_SPAN = 9'd60;
   localparam logic [7:0]  FULL_SCALE  = 8'd255;
   // floor(2^24 / 360); the quotient estimate is never more than one low.
   localparam logic [15:0] HUE_RECIP   = 16'd46603;
   localparam logic [7:0]  BRIGHT_RESET = 8'd255;

   typedef struct packed {
      logic        op;
      logic [15:0] hue;
      logic [7:0]  saturation;
      logic [7:0]  value_level;
      logic [7:0]  red_in;
      logic [7:0]  green_in;
      logic [7:0]  blue_in;
   } req_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
   } rsp_type;

   // Request after hue reduction: sector and the scaled remainder.
   typedef struct packed {
      logic       op;
      logic [7:0] saturation;
      logic [7:0] value_level;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
      logic [2:0] sector;
      logic [7:0] frac;
   } hue_res_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } color_type;

   // Per-stage load enables of the pipeline, one bit per register stage.
   typedef struct packed {
      logic [2:0] hue_ld;
      logic [2:0] mix_ld;
      logic [1:0] scale_ld;
   } pipe_ctl_type;

   // Exact floor(x / 255) for any x up to 65279, where the 8-bit result still fits.
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] xp;
      logic [16:0] sum;
      xp  = {1'b0, x} + 17'd1;
      sum = xp + (xp >> 8);
      return sum[15:8];
   endfunction

endpackage

// ----- hw/rtl/hsvb_hue.sv -----
module hsvb_hue
   import hsvb_pkg::*;
(
   input  logic        clock,
   input  logic [2:0]  stage_ld,
   input  req_type     req_payload,
   output hue_res_type hue_res
);

   logic [31:0] prod_ff, prod_in;
   req_type     req1_ff, req2_ff;
   logic [8:0]  h_ff, h_in;
   hue_res_type res_ff, res_in;

   logic [7:0]  q_est;
   logic [15:0] rem;
   logic [9:0]  rem_lo;
   logic [2:0]  sector;
   logic [8:0]  base;
   logic [5:0]  hm;
   logic [9:0]  hm17;

   // Reciprocal multiply for hue / 360.
   assign prod_in = 32'(req_payload.hue) * 32'(HUE_RECIP);

   // Remainder, then one correction step.
   assign q_est  = prod_ff[31:24];
   assign rem    = req1_ff.hue - 16'(q_est) * 16'(HUE_RANGE);
   assign rem_lo = rem[9:0];
   assign h_in   = (rem_lo >= HUE_RANGE) ? 9'(rem_lo - HUE_RANGE) : rem_lo[8:0];

   always_comb begin
      if (h_ff >= 9'(5 * SECTOR_SPAN)) begin
         sector = SECTOR_5;
         base   = 9'(5 * SECTOR_SPAN);
      end else if (h_ff >= 9'(4 * SECTOR_SPAN)) begin
         sector = SECTOR_4;
         base   = 9'(4 * SECTOR_SPAN);
      end else if (h_ff >= 9'(3 * SECTOR_SPAN)) begin
         sector = SECTOR_3;
         base   = 9'(3 * SECTOR_SPAN);
      end else if (h_ff >= 9'(2 * SECTOR_SPAN)) begin
         sector = SECTOR_2;
         base   = 9'(2 * SECTOR_SPAN);
      end else if (h_ff >= SECTOR_SPAN) begin
         sector = SECTOR_1;
         base   = SECTOR_SPAN;
      end else begin
         sector = SECTOR_0;
         base   = 9'd0;
      end
   end

   // (hm * 255) / 60 is exactly (hm * 17) / 4.
   assign hm   = 6'(h_ff - base);
   assign hm17 = {hm, 4'b0000} + 10'(hm);

   always_comb begin
      res_in.op          = req2_ff.op;
      res_in.saturation  = req2_ff.saturation;
      res_in.value_level = req2_ff.value_level;
      res_in.red_in      = req2_ff.red_in;
      res_in.green_in    = req2_ff.green_in;
      res_in.blue_in     = req2_ff.blue_in;
      res_in.sector      = sector;
      res_in.frac        = hm17[9:2];
   end

   always_ff @(posedge clock) begin
      if (stage_ld[0]) begin
         prod_ff <= prod_in;
         req1_ff <= req_payload;
      end
      if (stage_ld[1]) begin
         h_ff    <= h_in;
         req2_ff <= req1_ff;
      end
      if (stage_ld[2]) begin
         res_ff  <= res_in;
      end
   end

   assign hue_res = res_ff;

endmodule

// ----- hw/rtl/hsvb_mix.sv -----
module hsvb_mix
   import hsvb_pkg::*;
(
   input  logic        clock,
   input  logic [2:0]  stage_ld,
   input  hue_res_type hue_res,
   output color_type   color
);

   hue_res_type hr4_ff, hr5_ff;
   logic [15:0] ms_f_ff, ms_f_in;
   logic [15:0] ms_nf_ff, ms_nf_in;
   logic [15:0] mp_ff, mp_in;
   logic [15:0] mq_ff, mq_in;
   logic [15:0] mt_ff, mt_in;
   logic [7:0]  p_ff, p_in;
   color_type   color_ff, color_in;

   logic [7:0]  q_val, t_val, v_val;

   assign ms_f_in  = 16'(hue_res.saturation) * 16'(hue_res.frac);
   assign ms_nf_in = 16'(hue_res.saturation) * 16'(FULL_SCALE - hue_res.frac);
   assign mp_in    = 16'(hue_res.value_level) * 16'(FULL_SCALE - hue_res.saturation);

   assign mq_in = 16'(hr4_ff.value_level) * 16'(FULL_SCALE - div255(ms_f_ff));
   assign mt_in = 16'(hr4_ff.value_level) * 16'(FULL_SCALE - div255(ms_nf_ff));
   assign p_in  = div255(mp_ff);

   assign q_val = div255(mq_ff);
   assign t_val = div255(mt_ff);
   assign v_val = hr5_ff.value_level;

   always_comb begin
      if (hr5_ff.op == OP_RGB) begin
         color_in.red   = hr5_ff.red_in;
         color_in.green = hr5_ff.green_in;
         color_in.blue  = hr5_ff.blue_in;
      end else if (hr5_ff.saturation == 8'd0) begin
         color_in.red   = v_val;
         color_in.green = v_val;
         color_in.blue  = v_val;
      end else begin
         case (hr5_ff.sector)
            SECTOR_0: begin
               color_in = '{red: v_val, green: t_val, blue: p_ff};
            end
            SECTOR_1: begin
               color_in = '{red: q_val, green: v_val, blue: p_ff};
            end
            SECTOR_2: begin
               color_in = '{red: p_ff, green: v_val, blue: t_val};
            end
            SECTOR_3: begin
               color_in = '{red: p_ff, green: q_val, blue: v_val};
            end
            SECTOR_4: begin
               color_in = '{red: t_val, green: p_ff, blue: v_val};
            end
            default: begin
               color_in = '{red: v_val, green: p_ff, blue: q_val};
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ld[0]) begin
         hr4_ff   <= hue_res;
         ms_f_ff  <= ms_f_in;
         ms_nf_ff <= ms_nf_in;
         mp_ff    <= mp_in;
      end
      if (stage_ld[1]) begin
         hr5_ff <= hr4_ff;
         mq_ff  <= mq_in;
         mt_ff  <= mt_in;
         p_ff   <= p_in;
      end
      if (stage_ld[2]) begin
         color_ff <= color_in;
      end
   end

   assign color = color_ff;

endmodule

// ----- hw/rtl/hsvb_scale.sv -----
module hsvb_scale
   import hsvb_pkg::*;
(
   input  logic       clock,
   input  logic [1:0] stage_ld,
   input  color_type  color,
   input  logic [7:0] brightness,
   output rsp_type    rsp_payload
);

   logic [15:0] r_prod_ff, r_prod_in;
   logic [15:0] g_prod_ff, g_prod_in;
   logic [15:0] b_prod_ff, b_prod_in;
   rsp_type     rsp_ff, rsp_in;

   assign r_prod_in = 16'(color.red)   * 16'(brightness);
   assign g_prod_in = 16'(color.green) * 16'(brightness);
   assign b_prod_in = 16'(color.blue)  * 16'(brightness);

   assign rsp_in.red_out   = div255(r_prod_ff);
   assign rsp_in.green_out = div255(g_prod_ff);
   assign rsp_in.blue_out  = div255(b_prod_ff);

   always_ff @(posedge clock) begin
      if (stage_ld[0]) begin
         r_prod_ff <= r_prod_in;
         g_prod_ff <= g_prod_in;
         b_prod_ff <= b_prod_in;
      end
      if (stage_ld[1]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

// ----- hw/rtl/hsv_to_rgb_with_brightness.sv -----
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_payload (req_type)
// rsp       out        rsp_valid/rsp_stall  rsp_payload (rsp_type)
// csr       in         csr_wr_en            csr_wr_data (brightness)
//
// One beat per clock in steady state while the output is not stalled. A beat
// passes eight register stages; rsp_valid is the valid bit of the last one.
// Synchronous active-high reset clears the stage valid bits and sets
// brightness to full scale. A stall holds only the stages that are full
// up to the stalled output; empty stages keep filling, so bubbles collapse.
module hsv_to_rgb_with_brightness
   import hsvb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_payload,

   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_payload,

   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   localparam int NUM_STAGES = 8;

   // Stages 0-2 reduce the hue, 3-5 form the p, q and t terms and pick the
   // color, 6-7 apply brightness. Stage 7 is the output register.
   logic [NUM_STAGES-1:0] valid_ff, valid_in;
   logic [NUM_STAGES-1:0] stage_ready;
   logic [7:0]            brightness_ff, brightness_in;
   pipe_ctl_type          pipe_ctl;
   hue_res_type           hue_res;
   color_type             color;

   // A stage can load when it is empty or when the stage after it loads.
   // The chain runs from the output back to the input.
   always_comb begin
      stage_ready[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
   end

   // Each stage takes the valid bit of the stage before it when it loads.
   always_comb begin
      valid_in = valid_ff;
      if (stage_ready[0]) begin
         valid_in[0] = req_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
         if (stage_ready[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   assign pipe_ctl.hue_ld   = stage_ready[2:0];
   assign pipe_ctl.mix_ld   = stage_ready[5:3];
   assign pipe_ctl.scale_ld = stage_ready[7:6];

   assign req_stall = !stage_ready[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];

   // The user must rewrite brightness only while the pipeline is empty; the block
   // itself does not enforce this. So every stage may read the live register.
   assign brightness_in = csr_wr_en ? csr_wr_data : brightness_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         brightness_ff <= BRIGHT_RESET;
      end else begin
         valid_ff      <= valid_in;
         brightness_ff <= brightness_in;
      end
   end

   hsvb_hue u_hue (
      .clock       (clock),
      .stage_ld    (pipe_ctl.hue_ld),
      .req_payload (req_payload),
      .hue_res     (hue_res)
   );

   hsvb_mix u_mix (
      .clock    (clock),
      .stage_ld (pipe_ctl.mix_ld),
      .hue_res  (hue_res),
      .color    (color)
   );

   hsvb_scale u_scale (
      .clock       (clock),
      .stage_ld    (pipe_ctl.scale_ld),
      .color       (color),
      .brightness  (brightness_ff),
      .rsp_payload (rsp_payload)
   );

   // An accepted beat always lands in the first stage.
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> valid_ff[0])
      else $error("accepted beat did not enter the first stage");

   // A full pipeline behind a stalled output must push back on the input.
   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      (&valid_ff) && rsp_stall |-> req_stall)
      else $error("input not stalled with a full, blocked pipeline");

   // A held middle stage keeps its beat.
   a_hold_keeps: assert property (@(posedge clock) disable iff (reset)
      valid_ff[3] && !stage_ready[3] |=> valid_ff[3])
      else $error("held stage dropped its beat");

   // A beat leaving the output with nothing behind it leaves the output empty.
   a_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !valid_ff[NUM_STAGES-2] |=> !rsp_valid)
      else $error("output beat repeated");

endmodule

// ----- sim/hsv_to_rgb_with_brightness_checker.sv -----
`timescale 1ns / 100ps

// Watches both channels and the brightness port. It predicts each result
// beat and compares it with what the block delivers.
module hsv_to_rgb_with_brightness_checker
   import hsvb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  req_type    req_payload,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  rsp_type    rsp_payload,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   output int         mismatch_count,
   output int         colors_owed
);

   rsp_type    owed_colors[$];
   logic [7:0] brightness_copy = BRIGHT_RESET;
   int         error_tally = 0;

   function automatic logic [7:0] dim_level(input logic [7:0] level, input logic [7:0] bright);
      int unsigned prod;
      prod = int'(level) * int'(bright);
      return 8'(prod / 255);
   endfunction

   function automatic rsp_type predict_color(input req_type r, input logic [7:0] bright);
      int unsigned h, f, s, v;
      logic [2:0]  sector;
      logic [7:0]  p, q, t, red, grn, blu;
      rsp_type     c;
      s = 32'(r.saturation);
      v = 32'(r.value_level);
      if (r.op == OP_RGB) begin
         red = r.red_in;
         grn = r.green_in;
         blu = r.blue_in;
      end else if (s == 0) begin
         red = r.value_level;
         grn = r.value_level;
         blu = r.value_level;
      end else begin
         h      = int'(r.hue) % int'(HUE_RANGE);
         sector = 3'(h / int'(SECTOR_SPAN));
         f      = ((h % int'(SECTOR_SPAN)) * 255) / int'(SECTOR_SPAN);
         p      = 8'((v * (255 - s)) / 255);
         q      = 8'((v * (255 - (s * f) / 255)) / 255);
         t      = 8'((v * (255 - (s * (255 - f)) / 255)) / 255);
         case (sector)
            SECTOR_0: begin red = 8'(v); grn = t; blu = p; end
            SECTOR_1: begin red = q; grn = 8'(v); blu = p; end
            SECTOR_2: begin red = p; grn = 8'(v); blu = t; end
            SECTOR_3: begin red = p; grn = q; blu = 8'(v); end
            SECTOR_4: begin red = t; grn = p; blu = 8'(v); end
            default: begin red = 8'(v); grn = p; blu = q; end
         endcase
      end
      c.red_out   = dim_level(red, bright);
      c.green_out = dim_level(grn, bright);
      c.blue_out  = dim_level(blu, bright);
      return c;
   endfunction

   task automatic compare_channel(input string name, input logic [7:0] want,
                                  input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         error_tally++;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         owed_colors.delete();
         brightness_copy = BRIGHT_RESET;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (owed_colors.size() == 0) begin
               $error("result beat %0h arrived with nothing outstanding", rsp_payload);
               error_tally++;
            end else begin
               want = owed_colors.pop_front();
               compare_channel("red_out", want.red_out, rsp_payload.red_out);
               compare_channel("green_out", want.green_out, rsp_payload.green_out);
               compare_channel("blue_out", want.blue_out, rsp_payload.blue_out);
            end
         end
         if (req_valid && !req_stall)
            owed_colors.push_back(predict_color(req_payload, brightness_copy));
         if (csr_wr_en)
            brightness_copy = csr_wr_data;
      end
      colors_owed    <= owed_colors.size();
      mismatch_count <= error_tally;
   end

endmodule

// ----- sim/hsv_to_rgb_with_brightness_tb.sv -----
`timescale 1ns / 100ps

// Top of the bench. It drives color requests and brightness writes, makes
// the result side stall at random, and gives the verdict. All prediction and
// comparison lives in the checker instance.
module hsv_to_rgb_with_brightness_tb;
   import hsvb_pkg::*;

   // A run is declared hung after this many cycles without any beat moving.
   // The longest legitimate quiet stretch is a long stall or gap plus the passage
   // through the eight stages plus a settle pause, so this is generous.
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_BEATS    = 150;
   localparam int PHASE_COUNT    = 9;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_stall;
   req_type    req_payload = '0;
   logic       rsp_valid;
   logic       rsp_stall   = 1'b0;
   rsp_type    rsp_payload;
   logic       csr_wr_en   = 1'b0;
   logic [7:0] csr_wr_data = '0;

   // When set, neither the sender nor the receiver idles, so the pipeline
   // runs at full rate for a whole phase.
   logic       no_idle     = 1'b0;

   int         mismatch_count;
   int         colors_owed;
   int         idle_cycles = 0;

   always #5 clock = ~clock;

   hsv_to_rgb_with_brightness dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   hsv_to_rgb_with_brightness_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .colors_owed    (colors_owed)
   );

   // Gap lengths: mostly none or short, now and then a long one. The same
   // distribution serves the sender's gaps and the receiver's stalls.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle)
         return 0;
      if (roll < 55)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      if (roll < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Level values lean toward the edges, where the truncating divisions
   // and the gray case are most likely to go wrong.
   function automatic logic [7:0] pick_level();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10)
         return 8'd0;
      if (roll < 20)
         return 8'd255;
      if (roll < 25)
         return 8'd1;
      return 8'($urandom);
   endfunction

   // The unused half of each request is filled with noise, since the
   // block must ignore it.
   function automatic req_type hsv_req(input logic [15:0] h, input logic [7:0] s,
                                       input logic [7:0] v);
      req_type r;
      r.op          = OP_HSV;
      r.hue         = h;
      r.saturation  = s;
      r.value_level = v;
      r.red_in      = 8'($urandom);
      r.green_in    = 8'($urandom);
      r.blue_in     = 8'($urandom);
      return r;
   endfunction

   function automatic req_type rgb_req(input logic [7:0] red, input logic [7:0] grn,
                                       input logic [7:0] blu);
      req_type r;
      r.op          = OP_RGB;
      r.hue         = 16'($urandom);
      r.saturation  = 8'($urandom);
      r.value_level = 8'($urandom);
      r.red_in      = red;
      r.green_in    = grn;
      r.blue_in     = blu;
      return r;
   endfunction

   function automatic req_type random_request();
      req_type r;
      int      roll;
      logic [15:0] h;
      roll = $urandom_range(0, 99);
      // Most hues sit in the first turn, some anywhere in 16 bits, and some
      // right on or just below a sector boundary somewhere in the range.
      if (roll < 65)
         h = 16'($urandom_range(0, 359));
      else if (roll < 85)
         h = 16'($urandom);
      else
         h = 16'(60 * $urandom_range(1, 1092) - $urandom_range(0, 1));
      if ($urandom_range(0, 1) == 0)
         r = hsv_req(h, pick_level(), pick_level());
      else
         r = rgb_req(pick_level(), pick_level(), pick_level());
      return r;
   endfunction

   // Present one beat and return at the edge where it is taken. Valid stays
   // high when the next beat follows without a gap, so it is never lowered
   // and raised in the same step.
   task automatic send_beat(input req_type item);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
   endtask

   // Stop sending and wait until every outstanding color has come back.
   // The opening wait lets the owed count catch up with the last beat.
   // Every request yields a result, so an empty store means an idle block;
   // the extra cycles only cover the pipeline depth as a margin.
   task automatic drain();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (colors_owed != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_brightness(input logic [7:0] level);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= level;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
   endtask

   // Receiver: alternating runs of ready and stalled cycles.
   initial begin : stall_gen
      int n;
      @(posedge clock);
      forever begin
         n = pick_gap();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // Watchdog: any accepted beat on either channel proves progress.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [7:0] levels [PHASE_COUNT];
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, at the reset brightness. First the sector edges at
      // full saturation and value, then hue wrapping, the smallest nonzero
      // saturation, black, and the gray case with hues that would otherwise
      // land in sectors 0 and 5.
      send_beat(hsv_req(16'd0, 8'd255, 8'd255));
      send_beat(hsv_req(16'd59, 8'd255, 8'd255));
      send_beat(hsv_req(16'd60, 8'd255, 8'd255));
      send_beat(hsv_req(16'd119, 8'd255, 8'd255));
      send_beat(hsv_req(16'd120, 8'd255, 8'd255));
      send_beat(hsv_req(16'd179, 8'd255, 8'd255));
      send_beat(hsv_req(16'd180, 8'd255, 8'd255));
      send_beat(hsv_req(16'd239, 8'd255, 8'd255));
      send_beat(hsv_req(16'd240, 8'd255, 8'd255));
      send_beat(hsv_req(16'd299, 8'd255, 8'd255));
      send_beat(hsv_req(16'd300, 8'd255, 8'd255));
      send_beat(hsv_req(16'd359, 8'd255, 8'd255));
      send_beat(hsv_req(16'd360, 8'd255, 8'd255));
      send_beat(hsv_req(16'd65535, 8'd200, 8'd180));
      send_beat(hsv_req(16'd30, 8'd1, 8'd255));
      send_beat(hsv_req(16'd200, 8'd255, 8'd0));
      send_beat(hsv_req(16'd90, 8'd128, 8'd77));
      send_beat(hsv_req(16'd65535, 8'd0, 8'd255));
      send_beat(hsv_req(16'd45, 8'd0, 8'd0));
      send_beat(hsv_req(16'd300, 8'd0, 8'd123));
      // Direct colors, with noise on the HSV fields that must be ignored.
      send_beat(rgb_req(8'd0, 8'd0, 8'd0));
      send_beat(rgb_req(8'd255, 8'd255, 8'd255));
      send_beat(rgb_req(8'd255, 8'd0, 8'd170));
      send_beat(rgb_req(8'd1, 8'd128, 8'd254));
      drain();

      // Random phases, each at its own brightness: off, full, the smallest
      // and largest partial scales, mid scale and a few arbitrary ones.
      levels = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd128, 8'($urandom_range(2, 253)),
                 8'd170, 8'($urandom_range(2, 253)), 8'd255};
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         write_brightness(levels[phase]);
         no_idle <= (phase == 2 || phase == 6);
         for (int n = 0; n < PHASE_BEATS; n++) begin
            // Halfway through one phase the sender holds off until the
            // pipeline has emptied completely, then resumes.
            if (phase == 4 && n == PHASE_BEATS / 2)
               drain();
            send_beat(random_request());
         end
         drain();
      end

      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && colors_owed == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- hsv_to_rgb_with_brightness.f -----
hw/rtl/hsvb_pkg.sv
hw/rtl/hsvb_hue.sv
hw/rtl/hsvb_mix.sv
hw/rtl/hsvb_scale.sv
hw/rtl/hsv_to_rgb_with_brightness.sv
sim/hsv_to_rgb_with_brightness_checker.sv
sim/hsv_to_rgb_with_brightness_tb.sv
